// ===== hdl/arfc_pkg.sv =====
// Shared types and constants for the diagnostic-link response frame checker.
package arfc_pkg;

  localparam int unsigned ByteW = 8;

  // The length byte carries the mode and payload byte count plus this offset.
  localparam logic [ByteW-1:0] LenOffset     = 8'h55;
  // Longest legal frame: 0xff - 0x55 + 3 bytes.
  localparam logic [ByteW-1:0] MaxFrameBytes = 8'hff - LenOffset + 8'h03;
  localparam logic [ByteW-1:0] MinFrameBytes = 8'd4;
  // Byte positions counted from zero within a frame.
  localparam logic [ByteW-1:0] PosId         = 8'd0;
  localparam logic [ByteW-1:0] PosLen        = 8'd1;
  localparam logic [ByteW-1:0] PosMode       = 8'd2;
  localparam logic [ByteW-1:0] PosFirstPay   = 8'd3;
  localparam logic [ByteW-1:0] PosLastPay    = MaxFrameBytes - 8'd2;
  localparam logic [ByteW-1:0] PosMax        = 8'hff;

  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CfgEcuId        = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgExpectedMode = 8'd1;

  typedef enum logic [1:0] {
    FS_OK      = 2'd0,
    FS_SUM_LEN = 2'd1,
    FS_ID_MODE = 2'd2,
    FS_TRUNC   = 2'd3
  } frame_status_e;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             is_status;
    frame_status_e    frame_status;
  } arfc_result_t;

endpackage

// ===== hdl/arfc_frame_track.sv =====
// Per-frame byte tracking, header capture and end-of-frame status decision.
module arfc_frame_track (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [arfc_pkg::ByteW-1:0] rx_byte_i,
  input  logic                       last_byte_i,
  input  logic [arfc_pkg::ByteW-1:0] ecu_id_i,
  input  logic [arfc_pkg::ByteW-1:0] expected_mode_i,
  output logic                       res_valid_o,
  output arfc_pkg::arfc_result_t     res_o
);
  import arfc_pkg::*;

  logic [ByteW-1:0] byte_index_q, byte_index_d;
  logic [ByteW-1:0] running_sum_q, running_sum_d;
  logic [ByteW-1:0] length_field_q, length_field_d;
  logic             id_matches_q, id_matches_d;
  logic             mode_matches_q, mode_matches_d;
  logic [ByteW-1:0] sum_next;
  logic [ByteW-1:0] want_len;
  logic [ByteW-1:0] got_len;
  frame_status_e    status;

  assign sum_next = running_sum_q + rx_byte_i;
  assign want_len = length_field_q - LenOffset;
  // Frame length minus three equals position minus two on the last byte.
  assign got_len  = byte_index_q - 8'd2;

  always_comb begin
    priority if (byte_index_q < PosFirstPay || byte_index_q >= MaxFrameBytes) begin
      status = FS_TRUNC;
    end else if (sum_next != '0) begin
      status = FS_SUM_LEN;
    end else if (!id_matches_q) begin
      status = FS_ID_MODE;
    end else if (got_len != want_len) begin
      status = FS_SUM_LEN;
    end else if (!mode_matches_q) begin
      status = FS_ID_MODE;
    end else begin
      status = FS_OK;
    end
  end

  always_comb begin
    byte_index_d   = byte_index_q;
    running_sum_d  = running_sum_q;
    length_field_d = length_field_q;
    id_matches_d   = id_matches_q;
    mode_matches_d = mode_matches_q;
    res_valid_o    = 1'b0;
    res_o          = '{payload_byte: '0, is_status: 1'b0, frame_status: FS_OK};
    if (accept_i) begin
      if (last_byte_i) begin
        res_valid_o    = 1'b1;
        res_o.is_status    = 1'b1;
        res_o.frame_status = status;
        // clear frame state for the next frame
        byte_index_d   = '0;
        running_sum_d  = '0;
        length_field_d = '0;
        id_matches_d   = 1'b0;
        mode_matches_d = 1'b0;
      end else begin
        running_sum_d = sum_next;
        if (byte_index_q == PosId) begin
          id_matches_d = (rx_byte_i == ecu_id_i);
        end
        if (byte_index_q == PosLen) begin
          length_field_d = rx_byte_i;
        end
        if (byte_index_q == PosMode) begin
          mode_matches_d = (rx_byte_i == expected_mode_i);
        end
        // saturate the count on overlong frames
        if (byte_index_q != PosMax) begin
          byte_index_d = byte_index_q + 8'd1;
        end
        if (byte_index_q >= PosFirstPay && byte_index_q <= PosLastPay) begin
          res_valid_o        = 1'b1;
          res_o.payload_byte = rx_byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q   <= '0;
      running_sum_q  <= '0;
      length_field_q <= '0;
      id_matches_q   <= 1'b0;
      mode_matches_q <= 1'b0;
    end else begin
      byte_index_q   <= byte_index_d;
      running_sum_q  <= running_sum_d;
      length_field_q <= length_field_d;
      id_matches_q   <= id_matches_d;
      mode_matches_q <= mode_matches_d;
    end
  end

endmodule

// ===== hdl/arfc_out_buf.sv =====
// Result register with a one-beat skid stage so one more input beat is taken under output stall.
module arfc_out_buf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  arfc_pkg::arfc_result_t push_data_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output arfc_pkg::arfc_result_t out_data_o
);
  import arfc_pkg::*;

  logic         main_valid_q, main_valid_d;
  logic         skid_valid_q, skid_valid_d;
  arfc_result_t main_q, main_d;
  arfc_result_t skid_q, skid_d;
  logic         pop;

  assign pop         = main_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // no push while the skid stage holds a beat
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

// ===== hdl/aldl_response_frame_checker.sv =====
// Diagnostic-link response frame checker; results leave from a registered buffer.
// One byte per cycle unless stalled; each byte needs one 8-bit add and a few compares.
// Result register plus one-beat skid stage: input flows for one more result in a stall.
// Results: one per payload byte, one status beat on the last byte, none for header bytes.
// Reset zeroes the frame state, both config registers and the buffer valid flags.
module aldl_response_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [arfc_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                         last_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [arfc_pkg::ByteW-1:0]   payload_byte_o,
  output logic                         is_status_o,
  output logic [1:0]                   frame_status_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [arfc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [arfc_pkg::ByteW-1:0]   cfg_data_i
);
  import arfc_pkg::*;

  logic [ByteW-1:0] ecu_id_q;
  logic [ByteW-1:0] expected_mode_q;
  logic             accept;
  logic             res_valid;
  arfc_result_t     res;
  arfc_result_t     out_data;
  logic             buf_full;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = buf_full;
  assign accept      = in_valid_i && !buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecu_id_q        <= '0;
      expected_mode_q <= '0;
    end else if (cfg_valid_i) begin
      // drop writes beyond the register list
      if (cfg_index_i == CfgEcuId) begin
        ecu_id_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgExpectedMode) begin
        expected_mode_q <= cfg_data_i;
      end
    end
  end

  arfc_frame_track u_track (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .rx_byte_i       (rx_byte_i),
    .last_byte_i     (last_byte_i),
    .ecu_id_i        (ecu_id_q),
    .expected_mode_i (expected_mode_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  arfc_out_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign payload_byte_o = out_data.payload_byte;
  assign is_status_o    = out_data.is_status;
  assign frame_status_o = out_data.frame_status;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the response frame checker: frame stimulus, byte predictor, scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import arfc_pkg::*;

  localparam int ClkPeriod  = 8;
  localparam int IdleLimit  = 2000;
  localparam int PrintLimit = 100;
  localparam int RandBeats  = 80;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             is_last;
  } rx_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ByteW-1:0]   rx_byte = '0;
  logic               last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ByteW-1:0]   payload_byte;
  logic               is_status;
  logic [1:0]         frame_status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ByteW-1:0]   cfg_data = '0;

  aldl_response_frame_checker dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .payload_byte_o (payload_byte),
    .is_status_o    (is_status),
    .frame_status_o (frame_status),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Predictor state and register copies
  logic [ByteW-1:0] cfg_ecu_id = '0;
  logic [ByteW-1:0] cfg_mode = '0;
  logic [ByteW-1:0] frame_pos = '0;
  logic [ByteW-1:0] frame_sum = '0;
  logic [ByteW-1:0] len_byte = '0;
  logic             id_ok = 1'b0;
  logic             mode_ok = 1'b0;

  rx_beat_t     pending_beats[$];
  arfc_result_t expected_results[$];

  int beats_queued = 0;
  int beats_in = 0;
  int frames_built = 0;
  int payload_seen = 0;
  int status_seen = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int error_count = 0;
  int idle_cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= PrintLimit) begin
      $display("ERROR %0t: result %0d %s: got 0x%0h, expected 0x%0h",
               $realtime, results_seen, what, got, want);
    end
  endtask

  // Advance the frame state by one accepted byte and queue whatever it should produce.
  task automatic predict_beat(input logic [ByteW-1:0] b, input logic is_last);
    int               pos;
    int               flen;
    logic [ByteW-1:0] got_len;
    logic [ByteW-1:0] want_len;
    arfc_result_t     r;
    pos = frame_pos;
    frame_sum = frame_sum + b;
    r = '0;
    if (is_last) begin
      flen = pos + 1;
      got_len = 8'(flen - 3);
      want_len = len_byte - LenOffset;
      r.is_status = 1'b1;
      if (flen < int'(MinFrameBytes) || flen > int'(MaxFrameBytes)) begin
        r.frame_status = FS_TRUNC;
      end else if (frame_sum != '0) begin
        r.frame_status = FS_SUM_LEN;
      end else if (!id_ok) begin
        r.frame_status = FS_ID_MODE;
      end else if (got_len != want_len) begin
        r.frame_status = FS_SUM_LEN;
      end else if (!mode_ok) begin
        r.frame_status = FS_ID_MODE;
      end else begin
        r.frame_status = FS_OK;
      end
      expected_results.push_back(r);
      frame_pos = '0;
      frame_sum = '0;
      len_byte = '0;
      id_ok = 1'b0;
      mode_ok = 1'b0;
    end else begin
      case (frame_pos)
        PosId:   id_ok = (b == cfg_ecu_id);
        PosLen:  len_byte = b;
        PosMode: mode_ok = (b == cfg_mode);
        default: ;
      endcase
      if (frame_pos != PosMax) frame_pos = frame_pos + 8'd1;
      if (pos >= int'(PosFirstPay) && pos <= int'(PosLastPay)) begin
        r.payload_byte = b;
        expected_results.push_back(r);
      end
    end
  endtask

  // Driver: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk or negedge rst_n) begin
    logic     next_valid;
    rx_beat_t beat;
    if (!rst_n) begin
      in_valid <= 1'b0;
      rx_byte <= '0;
      last_byte <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        predict_beat(rx_byte, last_byte);
        beats_in++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_beats.size() > 0) begin
          beat = pending_beats.pop_front();
          rx_byte <= beat.data;
          last_byte <= beat.is_last;
          next_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // Receiver: stall pattern of its own, plus one long hold-off while the sender is busy
  int  stall_mode = 0;
  int  mode_left = 0;
  int  hold_left = 0;
  int  rx_cycle = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && results_seen >= 120 && pending_beats.size() > 20) begin
        long_hold_done = 1'b1;
        hold_left = 150;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 120);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((rx_cycle % 5) < 2);
        endcase
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    arfc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", payload_byte, 0);
      end else begin
        want = expected_results.pop_front();
        if (is_status !== want.is_status)
          report_mismatch("is_status", is_status, want.is_status);
        if (payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", payload_byte, want.payload_byte);
        if (frame_status !== want.frame_status)
          report_mismatch("frame_status", frame_status, want.frame_status);
        if (want.is_status) status_seen++;
        else payload_seen++;
      end
      results_seen++;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               IdleLimit, expected_results.size());
      $display("aldl_response_frame_checker regression: fail");
      $finish;
    end
  end

  task automatic queue_beat(input logic [ByteW-1:0] b, input logic is_last);
    rx_beat_t beat;
    beat.data = b;
    beat.is_last = is_last;
    pending_beats.push_back(beat);
    beats_queued++;
  endtask

  function automatic logic [ByteW-1:0] good_len(input int n_pay);
    return 8'(n_pay + 1 + int'(LenOffset));
  endfunction

  // pay_kind 0: random payload, 1: alternate 0x00 and 0xff
  task automatic queue_frame(input logic [ByteW-1:0] id_b, input logic [ByteW-1:0] len_b,
                             input logic [ByteW-1:0] mode_b, input int n_pay,
                             input int pay_kind, input bit sum_good);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] pay;
    logic [ByteW-1:0] chk;
    sum = id_b + len_b + mode_b;
    queue_beat(id_b, 1'b0);
    queue_beat(len_b, 1'b0);
    queue_beat(mode_b, 1'b0);
    for (int i = 0; i < n_pay; i++) begin
      pay = (pay_kind == 1) ? ((i % 2) ? 8'hff : 8'h00) : 8'($urandom);
      sum = sum + pay;
      queue_beat(pay, 1'b0);
    end
    chk = '0 - sum;
    if (!sum_good) chk = chk + 8'($urandom_range(1, 255));
    queue_beat(chk, 1'b1);
    frames_built++;
  endtask

  // Raw bytes with only the final one marked last: runts and line noise
  task automatic queue_raw(input int n);
    for (int i = 0; i < n; i++) queue_beat(8'($urandom), (i == n - 1));
    frames_built++;
  endtask

  // Register beats back to back; the caller drops valid after the last one
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CfgEcuId) cfg_ecu_id = val;
    else if (idx == CfgExpectedMode) cfg_mode = val;
    cfg_writes++;
  endtask

  // Hold until every queued byte is in and every result is out, then let the pipe settle
  task automatic wait_idle();
    do @(posedge clk);
    while (!(beats_in == beats_queued && expected_results.size() == 0));
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int n;
    int k;
    int phase_end;
    int rand_beats;
    logic [ByteW-1:0] flip;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CfgEcuId, 8'h10);
    write_reg(CfgExpectedMode, 8'h21);
    write_reg(8'h02, 8'h5a);
    write_reg(8'hff, 8'hc3);
    cfg_valid <= 1'b0;

    // Directed frames: shortest good, runts, payload extremes, each precedence step
    queue_frame(8'h10, good_len(0), 8'h21, 0, 0, 1'b1);
    queue_raw(1);
    queue_raw(3);
    queue_frame(8'h10, good_len(2), 8'h21, 2, 1, 1'b1);
    queue_frame(8'h11, good_len(0), 8'h21, 0, 0, 1'b0);
    queue_frame(8'h11, good_len(1), 8'h21, 0, 0, 1'b1);
    queue_frame(8'h10, good_len(0), 8'h20, 0, 0, 1'b1);
    queue_frame(8'h10, good_len(3), 8'h20, 0, 0, 1'b1);

    rand_beats = 0;
    for (int phase = 0; phase < 2 || rand_beats < RandBeats; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_reg(CfgEcuId, 8'h00);
          write_reg(CfgExpectedMode, 8'h00);
        end
        1: begin
          write_reg(CfgEcuId, 8'hff);
          write_reg(CfgExpectedMode, 8'hff);
        end
        default: begin
          write_reg(CfgEcuId, 8'($urandom));
          write_reg(CfgExpectedMode, 8'($urandom));
        end
      endcase
      if (phase % 2) write_reg(8'($urandom_range(2, 255)), 8'($urandom));
      cfg_valid <= 1'b0;

      // Longest legal frame, then one long enough to saturate the byte count
      if (phase == 0) queue_frame(cfg_ecu_id, good_len(169), cfg_mode, 169, 0, 1'b1);
      if (phase == 1) queue_frame(cfg_ecu_id, good_len(254), cfg_mode, 254, 0, 1'b1);

      phase_end = beats_queued + $urandom_range(30, 60);
      while (beats_queued < phase_end) begin
        k = beats_queued;
        n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
        flip = 8'($urandom_range(1, 255));
        case ($urandom_range(0, 99)) inside
          [0:64]:  queue_frame(cfg_ecu_id, good_len(n), cfg_mode, n, 0, 1'b1);
          [65:70]: queue_frame(cfg_ecu_id, good_len(n), cfg_mode, n, 0, 1'b0);
          [71:76]: queue_frame(cfg_ecu_id ^ flip, good_len(n), cfg_mode, n, 0, 1'b1);
          [77:82]: queue_frame(cfg_ecu_id, good_len(n) + flip, cfg_mode, n, 0, 1'b1);
          [83:88]: queue_frame(cfg_ecu_id, good_len(n), cfg_mode ^ flip, n, 0, 1'b1);
          [89:93]: queue_raw($urandom_range(1, 3));
          default: queue_raw($urandom_range(1, 12));
        endcase
        rand_beats += beats_queued - k;
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);

    $display("run covered %0d frames, %0d bytes in, %0d register writes",
             frames_built, beats_in, cfg_writes);
    $display("results checked: %0d payload beats, %0d status beats, %0d mismatches",
             payload_seen, status_seen, error_count);
    if (error_count == 0) begin
      $display("aldl_response_frame_checker regression: pass");
    end else begin
      $display("aldl_response_frame_checker regression: fail");
    end
    $finish;
  end

endmodule
